>>> rtl/mmt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mmt_pkg
// Shared sizes, codes and state encoding for the multimap table engine.
// ============================================================================
package mmt_pkg;

    // table sizing
    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int ENTRY_W    = KEY_W + VAL_W;
    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 2;
    localparam int REMOVED_W  = 6;
    localparam int S_TDATA_W  = KEY_W + VAL_W;
    localparam int M_TDATA_W  = ((VAL_W + REMOVED_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = KIND_W + 1;

    // input action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    // result kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_MATCH   = 2'd1,
        KIND_NOMATCH = 2'd2,
        KIND_DELETE  = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

>>> rtl/multimap_table_engine_top.sv
`timescale 1ns / 1ps
// ============================================================================
// multimap_table_engine_top
// Key/value multimap in arrival order with insert, search and delete-all.
// ============================================================================
// Usage:
// - input beats arrive on the s_ stream: s_tuser carries the action (insert,
//   search, delete), s_tdata carries key and value; action 3 is dropped
// - results leave on the m_ stream: one beat per insert or delete, one beat
//   per matching value for a search, up to MAX_RESULTS (stored order, last
//   one with m_tlast), or a single no-match beat
// - search and delete step a compare unit through the entry RAM, one stored
//   entry per cycle while no stalled receiver holds the scan; a full table
//   drops the insert and flags table_full
// - delete compacts the table in the same pass, writing kept entries back
//   through the RAM write port
// - s_tready is low while a search or delete is running and while the
//   output register holds a beat that the receiver has not taken
// - a stalled receiver freezes the scan on the next match; nothing is lost
// - reset empties the table (entry count to zero) and drops any pending beat
// ============================================================================
module multimap_table_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // match_value [31:0], removed_count [37:32], zero pad
    output logic [2:0]  m_tuser,   // kind [1:0], table_full [2]
    output logic        m_tlast    // last
);

    mmt_pkg::state_t                  state_reg, state_next;
    mmt_pkg::action_t                 op_reg, op_next;
    logic [mmt_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [mmt_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [mmt_pkg::CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [mmt_pkg::CNT_W-1:0]        kept_reg, kept_next;
    logic [mmt_pkg::CNT_W-1:0]        removed_reg, removed_next;
    logic [mmt_pkg::RES_W-1:0]        found_reg, found_next;
    logic                             data_vld_reg, data_vld_next;
    logic                             held_vld_reg, held_vld_next;
    logic [mmt_pkg::VAL_W-1:0]        held_val_reg, held_val_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    mmt_pkg::kind_t                   m_kind_reg, m_kind_next;
    logic                             m_full_reg, m_full_next;
    logic [mmt_pkg::VAL_W-1:0]        m_match_reg, m_match_next;
    logic [mmt_pkg::REMOVED_W-1:0]    m_removed_reg, m_removed_next;
    logic                             m_last_reg, m_last_next;

    logic                             ram_wr_en;
    logic [mmt_pkg::IDX_W-1:0]        ram_wr_addr;
    logic [mmt_pkg::ENTRY_W-1:0]      ram_wr_data;
    logic                             ram_rd_en;
    logic [mmt_pkg::ENTRY_W-1:0]      ram_rd_data;

    logic [mmt_pkg::KEY_W-1:0]        rd_key;
    logic [mmt_pkg::VAL_W-1:0]        rd_val;
    logic                             hit;
    logic                             out_free;
    logic                             stall;

    // entry store: value in the upper half, key in the lower half
    mmt_ram #(
        .WIDTH (mmt_pkg::ENTRY_W),
        .DEPTH (mmt_pkg::CAPACITY)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg[mmt_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign rd_key   = ram_rd_data[mmt_pkg::KEY_W-1:0];
    assign rd_val   = ram_rd_data[mmt_pkg::ENTRY_W-1:mmt_pkg::KEY_W];
    assign hit      = data_vld_reg && (rd_key == key_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // ports
    assign s_tready = (state_reg == mmt_pkg::ST_IDLE) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mmt_pkg::M_TDATA_W - mmt_pkg::VAL_W - mmt_pkg::REMOVED_W){1'b0}},
                       m_removed_reg, m_match_reg};
    assign m_tuser  = {m_full_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

    // sequencer: next state, scan step and output beat
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        kept_next      = kept_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        data_vld_next  = data_vld_reg;
        held_vld_next  = held_vld_reg;
        held_val_next  = held_val_reg;

        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_full_next    = m_full_reg;
        m_match_next   = m_match_reg;
        m_removed_next = m_removed_reg;
        m_last_next    = m_last_reg;

        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[mmt_pkg::IDX_W-1:0];
        ram_wr_data    = s_tdata;
        ram_rd_en      = 1'b0;
        stall          = 1'b0;

        case (state_reg)
            mmt_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (s_tuser)
                        mmt_pkg::ACT_INSERT: begin
                            m_tvalid_next  = 1'b1;
                            m_kind_next    = mmt_pkg::KIND_INSERT;
                            m_match_next   = '0;
                            m_removed_next = '0;
                            m_last_next    = 1'b1;
                            if (count_reg == mmt_pkg::CNT_W'(mmt_pkg::CAPACITY)) begin
                                m_full_next = 1'b1;
                            end else begin
                                m_full_next = 1'b0;
                                ram_wr_en   = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        mmt_pkg::ACT_SEARCH, mmt_pkg::ACT_DELETE: begin
                            op_next       = mmt_pkg::action_t'(s_tuser);
                            key_next      = s_tdata[mmt_pkg::KEY_W-1:0];
                            rd_idx_next   = '0;
                            kept_next     = '0;
                            removed_next  = '0;
                            found_next    = '0;
                            data_vld_next = 1'b0;
                            held_vld_next = 1'b0;
                            state_next    = mmt_pkg::ST_SCAN;
                        end
                        default: begin
                            // unknown action: beat is taken and dropped
                        end
                    endcase
                end
            end

            mmt_pkg::ST_SCAN: begin
                if (!data_vld_reg && (rd_idx_reg == count_reg)) begin
                    state_next = mmt_pkg::ST_FINISH;
                end else begin
                    // a second match cannot retire while the older one is blocked
                    stall = (op_reg == mmt_pkg::ACT_SEARCH) && hit && held_vld_reg
                            && !out_free;
                    if (!stall) begin
                        // issue the next read
                        if (rd_idx_reg != count_reg) begin
                            ram_rd_en     = 1'b1;
                            rd_idx_next   = rd_idx_reg + 1'b1;
                            data_vld_next = 1'b1;
                        end else begin
                            data_vld_next = 1'b0;
                        end
                        // retire the entry held in the RAM read register
                        if (data_vld_reg) begin
                            if (op_reg == mmt_pkg::ACT_SEARCH) begin
                                if (hit) begin
                                    if (held_vld_reg) begin
                                        m_tvalid_next  = 1'b1;
                                        m_kind_next    = mmt_pkg::KIND_MATCH;
                                        m_full_next    = 1'b0;
                                        m_match_next   = held_val_reg;
                                        m_removed_next = '0;
                                        m_last_next    = 1'b0;
                                    end
                                    held_val_next = rd_val;
                                    held_vld_next = 1'b1;
                                    found_next    = found_reg + 1'b1;
                                    if (found_reg ==
                                        mmt_pkg::RES_W'(mmt_pkg::MAX_RESULTS - 1)) begin
                                        state_next = mmt_pkg::ST_FINISH;
                                    end
                                end
                            end else begin
                                // delete: compact the kept entries downward
                                if (hit) begin
                                    removed_next = removed_reg + 1'b1;
                                end else begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = kept_reg[mmt_pkg::IDX_W-1:0];
                                    ram_wr_data = ram_rd_data;
                                    kept_next   = kept_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
            end

            mmt_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_full_next    = 1'b0;
                    m_last_next    = 1'b1;
                    m_match_next   = '0;
                    m_removed_next = '0;
                    if (op_reg == mmt_pkg::ACT_SEARCH) begin
                        if (held_vld_reg) begin
                            m_kind_next  = mmt_pkg::KIND_MATCH;
                            m_match_next = held_val_reg;
                        end else begin
                            m_kind_next  = mmt_pkg::KIND_NOMATCH;
                        end
                    end else begin
                        m_kind_next    = mmt_pkg::KIND_DELETE;
                        m_removed_next = mmt_pkg::REMOVED_W'(removed_reg);
                        count_next     = kept_reg;
                    end
                    held_vld_next = 1'b0;
                    data_vld_next = 1'b0;
                    state_next    = mmt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mmt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mmt_pkg::ST_IDLE;
            count_reg    <= '0;
            data_vld_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            data_vld_reg <= data_vld_next;
            held_vld_reg <= held_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // scan and output payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        kept_reg      <= kept_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
        held_val_reg  <= held_val_next;
        m_kind_reg    <= m_kind_next;
        m_full_reg    <= m_full_next;
        m_match_reg   <= m_match_next;
        m_removed_reg <= m_removed_next;
        m_last_reg    <= m_last_next;
    end

endmodule

>>> rtl/mmt_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mmt_ram
// Generic simple dual-port RAM, one write port, one read port, registered
// read data that holds while the read enable is low.
// ============================================================================
module mmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> verif/multimap_table_engine_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// multimap_table_engine_checker
// Watches both streams of the multimap table engine, keeps its own copy of
// the table, predicts the answers to each accepted command beat and compares
// every accepted result beat with the oldest predicted answer.
// ============================================================================
module multimap_table_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  logic [1:0]  s_tuser,   // action [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // match_value [31:0], removed_count [37:32], zero pad
    input  logic [2:0]  m_tuser,   // kind [1:0], table_full [2]
    input  logic        m_tlast,
    output int          mismatches,
    output int          outstanding
);

    // one predicted result beat
    typedef struct packed {
        mmt_pkg::kind_t                kind;
        logic                          full;
        logic [mmt_pkg::VAL_W-1:0]     match_value;
        logic [mmt_pkg::REMOVED_W-1:0] removed;
        logic                          last;
    } answer_t;

    // shadow table
    logic [mmt_pkg::KEY_W-1:0] shadow_keys [mmt_pkg::CAPACITY];
    logic [mmt_pkg::VAL_W-1:0] shadow_vals [mmt_pkg::CAPACITY];
    int                        shadow_count;

    answer_t pending_answers [$];
    int      beat_index;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        shadow_count = 0;
        beat_index   = 0;
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result beat %0d, %s: got %h, want %h",
                 beat_index, field, got, want);
        mismatches++;
    endtask

    function automatic void queue_answer(mmt_pkg::kind_t kind, logic full,
                                         logic [mmt_pkg::VAL_W-1:0] mv,
                                         logic [mmt_pkg::REMOVED_W-1:0] rc, logic last);
        answer_t a;
        a.kind        = kind;
        a.full        = full;
        a.match_value = mv;
        a.removed     = rc;
        a.last        = last;
        pending_answers.push_back(a);
    endfunction

    // apply one command to the shadow table and queue its answers
    function automatic void apply_command(logic [1:0] action,
                                          logic [mmt_pkg::KEY_W-1:0] key,
                                          logic [mmt_pkg::VAL_W-1:0] value);
        int hits;
        int emitted;
        int kept;
        int removed;
        hits    = 0;
        emitted = 0;
        kept    = 0;
        removed = 0;
        case (action)
            mmt_pkg::ACT_INSERT: begin
                if (shadow_count >= mmt_pkg::CAPACITY) begin
                    queue_answer(mmt_pkg::KIND_INSERT, 1'b1, '0, '0, 1'b1);
                end else begin
                    shadow_keys[shadow_count] = key;
                    shadow_vals[shadow_count] = value;
                    shadow_count++;
                    queue_answer(mmt_pkg::KIND_INSERT, 1'b0, '0, '0, 1'b1);
                end
            end
            mmt_pkg::ACT_SEARCH: begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] == key) hits++;
                if (hits > mmt_pkg::MAX_RESULTS) hits = mmt_pkg::MAX_RESULTS;
                if (hits == 0) begin
                    queue_answer(mmt_pkg::KIND_NOMATCH, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count && emitted < hits; i++) begin
                        if (shadow_keys[i] == key) begin
                            emitted++;
                            queue_answer(mmt_pkg::KIND_MATCH, 1'b0, shadow_vals[i], '0,
                                         emitted == hits);
                        end
                    end
                end
            end
            mmt_pkg::ACT_DELETE: begin
                // compact the survivors in place, order kept
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_keys[i] == key) begin
                        removed++;
                    end else begin
                        shadow_keys[kept] = shadow_keys[i];
                        shadow_vals[kept] = shadow_vals[i];
                        kept++;
                    end
                end
                shadow_count = kept;
                queue_answer(mmt_pkg::KIND_DELETE, 1'b0, '0,
                             removed[mmt_pkg::REMOVED_W-1:0], 1'b1);
            end
            default: begin
                // unknown action: no change, no answer
            end
        endcase
    endfunction

    // compare one result beat with the oldest prediction
    task automatic check_result();
        answer_t want;
        if (pending_answers.size() == 0) begin
            report_mismatch("unexpected beat", {29'd0, m_tuser}, 32'd0);
        end else begin
            want = pending_answers.pop_front();
            if (m_tuser[1:0] !== want.kind)
                report_mismatch("kind", {30'd0, m_tuser[1:0]}, {30'd0, want.kind});
            if (m_tuser[2] !== want.full)
                report_mismatch("table_full", {31'd0, m_tuser[2]}, {31'd0, want.full});
            if (m_tdata[31:0] !== want.match_value)
                report_mismatch("match_value", m_tdata[31:0], want.match_value);
            if (m_tdata[37:32] !== want.removed)
                report_mismatch("removed_count", {26'd0, m_tdata[37:32]},
                                {26'd0, want.removed});
            if (m_tlast !== want.last)
                report_mismatch("last", {31'd0, m_tlast}, {31'd0, want.last});
        end
        beat_index++;
    endtask

    // monitor both channels; results first, a command accepted at the same
    // edge cannot have produced a beat yet
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = 0;
            pending_answers.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
        outstanding = pending_answers.size();
    end

endmodule

>>> verif/multimap_table_engine_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// multimap_table_engine_top_tb
// Drives insert, search and delete beats into the multimap table engine with
// random gaps and receiver stalls, including a long receiver hold-off that
// backs up the input; a side checker predicts and compares every result.
// ============================================================================
module multimap_table_engine_top_tb;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 250;
    localparam int         RANDOM_ITEMS = 110;
    // action code that the engine takes and drops
    localparam logic [1:0] ACT_UNKNOWN  = 2'b11;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit sender_calm = 1'b0;

    logic [31:0] key_pool [8];

    always #4 aclk = ~aclk;

    multimap_table_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    multimap_table_engine_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one command beat and wait until it is taken
    task automatic send_command(logic [1:0] action, logic [31:0] key, logic [31:0] value);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {value, key};
        s_tuser  <= action;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return key_pool[$urandom_range(0, 7)];
    endfunction

    // result receiver: random stalls, two long hold-offs
    initial begin
        int gap;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 16 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (taken == 12 || taken == 120) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int          sent;
        int          roll;
        logic [1:0]  action;
        logic [31:0] key;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, key/value extremes, duplicates, unknown action
        send_command(mmt_pkg::ACT_SEARCH, 32'h0000_0001, 32'h0);
        send_command(mmt_pkg::ACT_DELETE, 32'h0000_0001, 32'h0);
        send_command(mmt_pkg::ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_command(mmt_pkg::ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_command(mmt_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_command(mmt_pkg::ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff);
        send_command(mmt_pkg::ACT_INSERT, 32'h8000_0000, 32'h0000_0001);
        send_command(mmt_pkg::ACT_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_command(mmt_pkg::ACT_SEARCH, 32'h8000_0000, 32'hffff_ffff);
        send_command(mmt_pkg::ACT_SEARCH, 32'h7fff_ffff, 32'h0);
        send_command(mmt_pkg::ACT_SEARCH, 32'h0001_2345, 32'h0);
        send_command(ACT_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
        send_command(mmt_pkg::ACT_DELETE, 32'h8000_0000, 32'hffff_ffff);
        send_command(mmt_pkg::ACT_SEARCH, 32'h8000_0000, 32'h0);
        send_command(mmt_pkg::ACT_SEARCH, 32'hffff_ffff, 32'h0);
        send_command(mmt_pkg::ACT_DELETE, 32'hffff_ffff, 32'h0);
        send_command(mmt_pkg::ACT_SEARCH, 32'h0000_0000, 32'h0);
        send_command(mmt_pkg::ACT_INSERT, 32'haaaa_5555, 32'h5555_aaaa);
        send_command(mmt_pkg::ACT_SEARCH, 32'haaaa_5555, 32'h0);
        send_command(mmt_pkg::ACT_DELETE, 32'h7fff_ffff, 32'h0);

        // random: fill, mixed traffic, then one hot key into a full table
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 16 == 0) sender_calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            key  = pick_key();
            if (sent < 40) begin
                action = (roll < 90) ? mmt_pkg::ACT_INSERT :
                         (roll < 97) ? mmt_pkg::ACT_SEARCH : mmt_pkg::ACT_DELETE;
            end else if (sent < 80) begin
                action = (roll < 40) ? mmt_pkg::ACT_INSERT :
                         (roll < 75) ? mmt_pkg::ACT_SEARCH :
                         (roll < 95) ? mmt_pkg::ACT_DELETE : ACT_UNKNOWN;
            end else begin
                action = (roll < 85) ? mmt_pkg::ACT_INSERT :
                         (roll < 95) ? mmt_pkg::ACT_SEARCH : mmt_pkg::ACT_DELETE;
                if (action == mmt_pkg::ACT_DELETE) key = key_pool[$urandom_range(1, 7)];
                else if ($urandom_range(0, 9) != 0) key = key_pool[0];
            end
            send_command(action, key, $urandom);
            if (action != ACT_UNKNOWN) sent++;
        end
        send_command(mmt_pkg::ACT_SEARCH, key_pool[0], $urandom);
        send_command(mmt_pkg::ACT_DELETE, key_pool[0], $urandom);
        send_command(mmt_pkg::ACT_SEARCH, key_pool[0], $urandom);
        s_tvalid <= 1'b0;

        // drain, then let the engine settle
        do @(negedge aclk); while (outstanding != 0);
        repeat (mmt_pkg::CAPACITY + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mmt_pkg.sv
rtl/mmt_ram.sv
rtl/multimap_table_engine_top.sv
verif/multimap_table_engine_checker.sv
verif/multimap_table_engine_top_tb.sv
